// ===== design/two_dim_parity_block_decoder_assert.svh =====
// Assertion macros shared by the checker of the 2-D parity block decoder.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TWO_DIM_PARITY_BLOCK_DECODER_ASSERT_SVH
`define TWO_DIM_PARITY_BLOCK_DECODER_ASSERT_SVH

// same-cycle implication
`define TDPBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TDPBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tdpbd_pkg.sv =====
// Package for the 2-D parity block decoder: geometry constants and item types.
// No dependencies; imported by every module of the block.
package tdpbd_pkg;

   localparam int COLUMN_COUNT = 6;
   localparam int ROW_COUNT    = 3;
   localparam int HEADER_BITS  = 16;
   localparam int BYTE_BITS    = 8;

   localparam int DATA_COUNT = ROW_COUNT * COLUMN_COUNT;
   localparam int ROW_W      = $clog2(ROW_COUNT + 1);
   localparam int COL_W      = $clog2(COLUMN_COUNT + 1);
   localparam int RIDX_W     = $clog2(ROW_COUNT);
   localparam int CIDX_W     = $clog2(COLUMN_COUNT);
   localparam int VALID_W    = $clog2(DATA_COUNT + 1);
   localparam int NBITS_W    = $clog2(BYTE_BITS + 1);

   localparam int FIFO_DEPTH = 2;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

   typedef logic [ROW_COUNT-1:0][COLUMN_COUNT-1:0] data_grid_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] encoded_byte;
      logic                 last_byte;
   } req_type;

   typedef struct packed {
      logic [DATA_COUNT-1:0] data_bits;
      logic [VALID_W-1:0]    valid_bits;
      logic                  last_block;
      logic [VALID_W-1:0]    flipped_count;
   } rsp_type;

   // completed block handed from the front to the back
   typedef struct packed {
      data_grid_type         data;
      logic [ROW_COUNT-1:0]  row_bad;
      logic [COLUMN_COUNT-1:0] col_bad;
      logic                  last;
      logic [BYTE_BITS-1:0]  cutoff;
   } blk_type;

endpackage

// ===== design/tdpbd_front.sv =====
// Front of the decoder: header parsing and per-byte parity accumulation.
// Depends on tdpbd_pkg; pushes completed blocks into tdpbd_fifo.
module tdpbd_front
   import tdpbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_payload,
   output logic    push,
   output blk_type push_blk
);

   typedef enum logic [1:0] {HDR_PAD, HDR_CUT, HDR_DATA} hdr_state_type;

   hdr_state_type           hdr_ff, hdr_in;
   logic [BYTE_BITS-1:0]    pad_ff, pad_in;
   logic [BYTE_BITS-1:0]    cut_ff, cut_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COL_W-1:0]        col_ff, col_in;
   data_grid_type           data_ff, data_in;
   logic [ROW_COUNT-1:0]    rrun_ff, rrun_in;
   logic [ROW_COUNT-1:0]    rrcv_ff, rrcv_in;
   logic [COLUMN_COUNT-1:0] crun_ff, crun_in;
   logic [COLUMN_COUNT-1:0] crcv_ff, crcv_in;
   logic                    push_in;
   blk_type                 blk_in;
   logic [NBITS_W-1:0]      nbits;
   logic                    bit_v;

   always_comb begin
      hdr_in  = hdr_ff;
      pad_in  = pad_ff;
      cut_in  = cut_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      data_in = data_ff;
      rrun_in = rrun_ff;
      rrcv_in = rrcv_ff;
      crun_in = crun_ff;
      crcv_in = crcv_ff;
      push_in = 1'b0;
      blk_in  = '0;
      bit_v   = 1'b0;
      nbits   = NBITS_W'(BYTE_BITS);
      if (req_payload.last_byte) begin
         nbits = (pad_ff >= BYTE_BITS) ? '0 :
                 NBITS_W'(BYTE_BITS) - NBITS_W'(pad_ff);
      end
      if (accept) begin
         case (hdr_ff)
            HDR_PAD: begin
               pad_in = req_payload.encoded_byte;
               hdr_in = HDR_CUT;
            end
            HDR_CUT: begin
               cut_in = req_payload.encoded_byte;
               hdr_in = HDR_DATA;
            end
            HDR_DATA: begin
               for (int i = 0; i < BYTE_BITS; i++) begin
                  if (NBITS_W'(i) < nbits) begin
                     bit_v = req_payload.encoded_byte[BYTE_BITS-1-i];
                     if (row_in < ROW_W'(ROW_COUNT)) begin
                        if (col_in < COL_W'(COLUMN_COUNT)) begin
                           data_in[row_in[RIDX_W-1:0]][col_in[CIDX_W-1:0]] = bit_v;
                           rrun_in[row_in[RIDX_W-1:0]] ^= bit_v;
                           crun_in[col_in[CIDX_W-1:0]] ^= bit_v;
                        end else begin
                           rrcv_in[row_in[RIDX_W-1:0]] |= bit_v;
                        end
                     end else if (col_in < COL_W'(COLUMN_COUNT)) begin
                        crcv_in[col_in[CIDX_W-1:0]] |= bit_v;
                     end
                     if (row_in == ROW_W'(ROW_COUNT) && col_in == COL_W'(COLUMN_COUNT)) begin
                        // corner bit closes the block
                        push_in        = 1'b1;
                        blk_in.data    = data_in;
                        blk_in.row_bad = rrun_in ^ rrcv_in;
                        blk_in.col_bad = crun_in ^ crcv_in;
                        blk_in.last    = req_payload.last_byte;
                        blk_in.cutoff  = cut_ff;
                        row_in  = '0;
                        col_in  = '0;
                        data_in = '0;
                        rrun_in = '0;
                        rrcv_in = '0;
                        crun_in = '0;
                        crcv_in = '0;
                     end else if (col_in == COL_W'(COLUMN_COUNT)) begin
                        col_in = '0;
                        row_in = row_in + ROW_W'(1);
                     end else begin
                        col_in = col_in + COL_W'(1);
                     end
                  end
               end
            end
            default: hdr_in = HDR_PAD;
         endcase
         if (req_payload.last_byte) begin
            hdr_in  = HDR_PAD;
            pad_in  = '0;
            cut_in  = '0;
            row_in  = '0;
            col_in  = '0;
            data_in = '0;
            rrun_in = '0;
            rrcv_in = '0;
            crun_in = '0;
            crcv_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff  <= HDR_PAD;
         pad_ff  <= '0;
         cut_ff  <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
         data_ff <= '0;
         rrun_ff <= '0;
         rrcv_ff <= '0;
         crun_ff <= '0;
         crcv_ff <= '0;
      end else begin
         hdr_ff  <= hdr_in;
         pad_ff  <= pad_in;
         cut_ff  <= cut_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         data_ff <= data_in;
         rrun_ff <= rrun_in;
         rrcv_ff <= rrcv_in;
         crun_ff <= crun_in;
         crcv_ff <= crcv_in;
      end
   end

   assign push     = push_in;
   assign push_blk = blk_in;

endmodule

// ===== design/tdpbd_fifo.sv =====
// Short block queue between the front and back of the decoder.
// Depends on tdpbd_pkg for the block type and depth.
module tdpbd_fifo
   import tdpbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  blk_type push_blk,
   input  logic    pop,
   output blk_type head_blk,
   output logic    full,
   output logic    empty
);

   blk_type             mem_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0]   wr_ff, wr_in;
   logic [FPTR_W-1:0]   rd_ff, rd_in;
   logic [FCNT_W-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == FCNT_W'(FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_blk = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ff + FPTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ff + FPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + FCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - FCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_blk;
      end
   end

endmodule

// ===== design/tdpbd_back.sv =====
// Back of the decoder: error correction, counts and the result register.
// Depends on tdpbd_pkg; pops blocks from tdpbd_fifo.
module tdpbd_back
   import tdpbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    empty,
   input  blk_type head_blk,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   data_grid_type mask;

   assign pop = !empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int r = 0; r < ROW_COUNT; r++) begin
         for (int c = 0; c < COLUMN_COUNT; c++) begin
            mask[r][c] = head_blk.row_bad[r] & head_blk.col_bad[c];
         end
      end
      rsp_in.data_bits     = head_blk.data ^ mask;
      rsp_in.flipped_count = VALID_W'($countones(mask));
      rsp_in.last_block    = head_blk.last;
      rsp_in.valid_bits    = VALID_W'(DATA_COUNT);
      if (head_blk.last) begin
         rsp_in.valid_bits = (head_blk.cutoff >= BYTE_BITS'(DATA_COUNT)) ? '0 :
            VALID_W'(BYTE_BITS'(DATA_COUNT) - head_blk.cutoff);
      end
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/two_dim_parity_block_decoder.sv =====
// Top level of the 2-D parity block decoder (3 rows x 6 columns).
// Depends on tdpbd_pkg, tdpbd_front, tdpbd_fifo and tdpbd_back.
//
// Input channel req_*: one encoded byte per item, bit 7 first, last_byte marks
// the final byte of a stream. The first two bytes of a stream are the header
// (padding bit count, then cutoff bit count); every further byte is data.
// Result channel rsp_*: one item per completed 28-bit block with 18 corrected
// data bits (bit 0 first), the count of valid bits, last_block and the number
// of corrected bits. Bytes that do not complete a block give no result.
// Throughput: one byte per cycle while req_stall is low. The block queue is
// written when the byte completing a block is accepted, and the output register
// is loaded from the queue head once it holds no stalled result.
// req_stall rises only when the block queue is full, which happens only while
// rsp_stall holds results back; a stalled result holds its payload.
// Reset (synchronous) returns to header parsing and empties the queue and the
// output register. After the last byte of a stream the block is back in
// header parsing; an incomplete trailing block is dropped.
module two_dim_parity_block_decoder
   import tdpbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    accept;
   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   blk_type push_blk;
   blk_type head_blk;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   tdpbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .push        (push),
      .push_blk    (push_blk)
   );

   tdpbd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_blk (push_blk),
      .pop      (pop),
      .head_blk (head_blk),
      .full     (full),
      .empty    (empty)
   );

   tdpbd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .head_blk    (head_blk),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/tdpbd_checker.sv =====
// Port-level checks for the 2-D parity block decoder, bound to the top level.
// Depends on tdpbd_pkg and two_dim_parity_block_decoder_assert.svh.
`include "two_dim_parity_block_decoder_assert.svh"

module tdpbd_checker
   import tdpbd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   `TDPBD_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid, "result after reset")
   `TDPBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload), "stalled result changed")
   `TDPBD_ASSERT_NOW(a_full_block, clock, reset, rsp_valid && !rsp_payload.last_block,
      rsp_payload.valid_bits == VALID_W'(DATA_COUNT), "short block before end of stream")
   `TDPBD_ASSERT_NOW(a_flip_range, clock, reset, rsp_valid,
      rsp_payload.flipped_count <= VALID_W'(DATA_COUNT), "flip count out of range")

endmodule

bind two_dim_parity_block_decoder tdpbd_checker u_checker (.*);
